// ===== hdl/nkil_pkg.sv =====
// ----------------------------------------------------------------------------
// nkil_pkg
// Types, widths and codes shared by the nearest-K insertion list.
// ----------------------------------------------------------------------------
package nkil_pkg;

  localparam int unsigned LIST_CAPACITY_DEF = 128;

  localparam int unsigned KEEP_COUNT_W  = 8;
  localparam int unsigned RANGE_LIMIT_W = 13;
  localparam int unsigned DIST_W        = 19;
  localparam int unsigned TAG_W         = 16;
  localparam int unsigned RIDX_W        = 7;
  localparam int unsigned POS_W         = 7;
  localparam int unsigned KEPT_W        = 8;
  localparam int unsigned TOTAL_W       = 16;
  localparam int unsigned CFG_IDX_W     = 1;
  localparam int unsigned CFG_DATA_W    = 13;
  localparam int unsigned READ_GROUP    = 16;

  localparam logic [KEEP_COUNT_W-1:0]  KEEP_COUNT_RST  = 8'd20;
  localparam logic [RANGE_LIMIT_W-1:0] RANGE_LIMIT_RST = 13'd800;
  localparam logic [TOTAL_W-1:0]       TOTAL_MAX       = 16'hFFFF;

  typedef enum logic [1:0] {
    MODE_CLEAR = 2'd0,
    MODE_OFFER = 2'd1,
    MODE_READ  = 2'd2,
    MODE_IDLE  = 2'd3
  } mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_KEEP_COUNT  = 1'b0,
    CFG_RANGE_LIMIT = 1'b1
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_EXEC = 2'd1,
    ST_DONE = 2'd2
  } state_e;

  typedef struct packed {
    mode_e                mode;
    logic [DIST_W-1:0]    distance;
    logic [TAG_W-1:0]     tag;
    logic [RIDX_W-1:0]    read_index;
  } in_item_t;

  typedef struct packed {
    logic                 accepted;
    logic [POS_W-1:0]     insert_position;
    logic [KEPT_W-1:0]    kept_count;
    logic [TOTAL_W-1:0]   in_range_count;
    logic                 read_valid;
    logic [DIST_W-1:0]    read_distance;
    logic [TAG_W-1:0]     read_tag;
  } out_item_t;

  // Broadcast from the control to every cell.
  typedef struct packed {
    logic                 ins;
    logic [DIST_W-1:0]    distance;
    logic [TAG_W-1:0]     tag;
  } cell_bcast_t;

  // What a cell shows its right neighbor and the read tree.
  typedef struct packed {
    logic                 le;
    logic [DIST_W-1:0]    distance;
    logic [TAG_W-1:0]     tag;
  } cell_data_t;

endpackage

// ===== hdl/nkil_cell.sv =====
// ----------------------------------------------------------------------------
// nkil_cell
// One list slot: compares its entry with the candidate, then keeps its entry,
// takes the candidate, or takes the entry of its left neighbor.
// ----------------------------------------------------------------------------
module nkil_cell #(
  parameter int unsigned CNT_W = 8,
  parameter int unsigned IDX   = 0
) (
  input  logic                  clk_i,
  input  nkil_pkg::cell_bcast_t bcast_i,
  input  logic [CNT_W-1:0]      span_i,
  input  logic [CNT_W-1:0]      last_i,
  input  nkil_pkg::cell_data_t  left_i,
  output nkil_pkg::cell_data_t  cell_o,
  output logic                  last_hit_o,
  output logic                  take_new_o
);

  localparam logic [CNT_W-1:0] MyIdx = CNT_W'(IDX);

  logic [nkil_pkg::DIST_W-1:0] dist_q, dist_d;
  logic [nkil_pkg::TAG_W-1:0]  tag_q, tag_d;
  logic raw_le, in_span, active, le, take_new, take_left;

  always_comb begin
    raw_le    = (dist_q <= bcast_i.distance);
    in_span   = (MyIdx < span_i);
    active    = (MyIdx <= span_i);
    le        = in_span & raw_le;
    // first slot past the run of entries not farther than the candidate
    take_new  = active & ~le & left_i.le;
    take_left = active & ~le & ~left_i.le;
    dist_d    = dist_q;
    tag_d     = tag_q;
    if (bcast_i.ins) begin
      if (take_new) begin
        dist_d = bcast_i.distance;
        tag_d  = bcast_i.tag;
      end else if (take_left) begin
        dist_d = left_i.distance;
        tag_d  = left_i.tag;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    dist_q <= dist_d;
    tag_q  <= tag_d;
  end

  assign cell_o.le       = le;
  assign cell_o.distance = dist_q;
  assign cell_o.tag      = tag_q;
  assign last_hit_o      = (MyIdx == last_i) & raw_le;
  assign take_new_o      = take_new;

endmodule

// ===== hdl/nkil_read_tree.sv =====
// ----------------------------------------------------------------------------
// nkil_read_tree
// Selects one cell entry by index: registered group partials, then a final
// OR across the groups.
// ----------------------------------------------------------------------------
module nkil_read_tree #(
  parameter int unsigned LIST_CAPACITY = nkil_pkg::LIST_CAPACITY_DEF
) (
  input  logic                                           clk_i,
  input  logic                                           en_i,
  input  logic [nkil_pkg::RIDX_W-1:0]                    read_index_i,
  input  nkil_pkg::cell_data_t [LIST_CAPACITY-1:0]       cells_i,
  output logic [nkil_pkg::DIST_W-1:0]                    dist_o,
  output logic [nkil_pkg::TAG_W-1:0]                     tag_o
);

  localparam int unsigned GroupSize = nkil_pkg::READ_GROUP;
  localparam int unsigned NumGroups = (LIST_CAPACITY + GroupSize - 1) / GroupSize;

  logic [nkil_pkg::DIST_W-1:0] grp_dist_q [NumGroups];
  logic [nkil_pkg::DIST_W-1:0] grp_dist_d [NumGroups];
  logic [nkil_pkg::TAG_W-1:0]  grp_tag_q  [NumGroups];
  logic [nkil_pkg::TAG_W-1:0]  grp_tag_d  [NumGroups];

  always_comb begin
    int idx;
    for (int g = 0; g < NumGroups; g++) begin
      grp_dist_d[g] = '0;
      grp_tag_d[g]  = '0;
      for (int j = 0; j < GroupSize; j++) begin
        idx = g * GroupSize + j;
        if (idx < LIST_CAPACITY && int'(read_index_i) == idx) begin
          grp_dist_d[g] = grp_dist_d[g] | cells_i[idx].distance;
          grp_tag_d[g]  = grp_tag_d[g]  | cells_i[idx].tag;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      grp_dist_q <= grp_dist_d;
      grp_tag_q  <= grp_tag_d;
    end
  end

  always_comb begin
    dist_o = '0;
    tag_o  = '0;
    for (int g = 0; g < NumGroups; g++) begin
      dist_o = dist_o | grp_dist_q[g];
      tag_o  = tag_o  | grp_tag_q[g];
    end
  end

endmodule

// ===== hdl/nearest_k_insertion_list_core.sv =====
// ----------------------------------------------------------------------------
// nearest_k_insertion_list_core
// Keeps the K nearest candidates of a scan in ascending distance order.
// ----------------------------------------------------------------------------
// Each transaction passes through the control states in turn: idle registers
// the item; in execute every cell of the chain compares its entry with the
// candidate and shifts or loads in parallel (a read registers the group
// partials of the read tree in the same cycle); done merges the read tree and
// loads the output register. The next item is taken while a result waits in
// the output register; a held result stalls the done state.
// List entries have no reset; entries below the kept count are always written.
module nearest_k_insertion_list_core #(
  parameter int unsigned LIST_CAPACITY = nkil_pkg::LIST_CAPACITY_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  nkil_pkg::in_item_t                 in_data_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output nkil_pkg::out_item_t                out_data_o,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [nkil_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [nkil_pkg::CFG_DATA_W-1:0]    cfg_data_i
);

  localparam int unsigned CntW = $clog2(LIST_CAPACITY + 1);
  localparam int unsigned PosW = (LIST_CAPACITY > 1) ? $clog2(LIST_CAPACITY) : 1;
  localparam int unsigned KeepExtW = nkil_pkg::KEEP_COUNT_W + 1;

  nkil_pkg::state_e state_q, state_d;
  logic exec_en, load_out;

  nkil_pkg::in_item_t                       item_q;
  logic [nkil_pkg::KEEP_COUNT_W-1:0]        keep_count_q;
  logic [nkil_pkg::RANGE_LIMIT_W-1:0]       range_limit_q;
  logic [CntW-1:0]                          len_q, len_d;
  logic [nkil_pkg::TOTAL_W-1:0]             total_q, total_d;
  logic                                     acc_q;
  logic [PosW-1:0]                          pos_q;
  logic                                     rv_q;
  logic                                     out_valid_q;
  nkil_pkg::out_item_t                      out_q;

  logic [KeepExtW-1:0] keep_ext;
  logic [CntW-1:0]     limit, last, span;
  logic                full, offer, within_limit, reject, ins;
  logic [PosW-1:0]     pos_enc;

  nkil_pkg::cell_bcast_t                     bcast;
  nkil_pkg::cell_data_t [LIST_CAPACITY-1:0]  cell_vec;
  nkil_pkg::cell_data_t                      head_left;
  logic [LIST_CAPACITY-1:0]                  last_hit_vec, take_new_vec;
  logic [nkil_pkg::DIST_W-1:0]               rd_dist;
  logic [nkil_pkg::TAG_W-1:0]                rd_tag;

  // ---------------- control FSM ----------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      nkil_pkg::ST_IDLE: if (in_valid_i) state_d = nkil_pkg::ST_EXEC;
      nkil_pkg::ST_EXEC: state_d = nkil_pkg::ST_DONE;
      nkil_pkg::ST_DONE: if (!out_valid_q || !out_stall_i) state_d = nkil_pkg::ST_IDLE;
      default:           state_d = nkil_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall_o = 1'b1;
    exec_en    = 1'b0;
    load_out   = 1'b0;
    unique case (state_q)
      nkil_pkg::ST_IDLE: in_stall_o = 1'b0;
      nkil_pkg::ST_EXEC: exec_en = 1'b1;
      nkil_pkg::ST_DONE: load_out = !out_valid_q || !out_stall_i;
      default:           in_stall_o = 1'b1;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= nkil_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      item_q <= in_data_i;
    end
  end

  // ---------------- configuration ----------------
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      keep_count_q  <= nkil_pkg::KEEP_COUNT_RST;
      range_limit_q <= nkil_pkg::RANGE_LIMIT_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (nkil_pkg::cfg_idx_e'(cfg_index_i))
        nkil_pkg::CFG_KEEP_COUNT:  keep_count_q  <= cfg_data_i[nkil_pkg::KEEP_COUNT_W-1:0];
        nkil_pkg::CFG_RANGE_LIMIT: range_limit_q <= cfg_data_i;
        default:                   keep_count_q  <= keep_count_q;
      endcase
    end
  end

  // ---------------- list control ----------------
  always_comb begin
    // clamp keep count to 1..capacity
    keep_ext = KeepExtW'(keep_count_q);
    if (keep_ext == '0) keep_ext = KeepExtW'(1);
    if (keep_ext > KeepExtW'(LIST_CAPACITY)) keep_ext = KeepExtW'(LIST_CAPACITY);
    limit        = CntW'(keep_ext);
    full         = (len_q >= limit);
    last         = limit - CntW'(1);
    span         = full ? last : len_q;
    offer        = exec_en && (item_q.mode == nkil_pkg::MODE_OFFER);
    within_limit = (item_q.distance <= nkil_pkg::DIST_W'(range_limit_q));
    reject       = full && (|last_hit_vec);
    ins          = offer && within_limit && !reject;
  end

  always_comb begin
    pos_enc = '0;
    for (int i = 0; i < LIST_CAPACITY; i++) begin
      if (take_new_vec[i]) pos_enc = pos_enc | PosW'(i);
    end
  end

  assign bcast.ins      = ins;
  assign bcast.distance = item_q.distance;
  assign bcast.tag      = item_q.tag;

  // head of the chain sees a left neighbor that is never farther
  assign head_left.le       = 1'b1;
  assign head_left.distance = '0;
  assign head_left.tag      = '0;

  for (genvar i = 0; i < LIST_CAPACITY; i++) begin : g_cell
    nkil_cell #(
      .CNT_W (CntW),
      .IDX   (i)
    ) u_cell (
      .clk_i      (clk_i),
      .bcast_i    (bcast),
      .span_i     (span),
      .last_i     (last),
      .left_i     ((i == 0) ? head_left : cell_vec[(i == 0) ? 0 : i - 1]),
      .cell_o     (cell_vec[i]),
      .last_hit_o (last_hit_vec[i]),
      .take_new_o (take_new_vec[i])
    );
  end

  nkil_read_tree #(
    .LIST_CAPACITY (LIST_CAPACITY)
  ) u_read_tree (
    .clk_i        (clk_i),
    .en_i         (exec_en),
    .read_index_i (item_q.read_index),
    .cells_i      (cell_vec),
    .dist_o       (rd_dist),
    .tag_o        (rd_tag)
  );

  always_comb begin
    len_d   = len_q;
    total_d = total_q;
    if (exec_en) begin
      if (item_q.mode == nkil_pkg::MODE_CLEAR) begin
        len_d   = '0;
        total_d = '0;
      end else begin
        if (ins && !full) len_d = len_q + CntW'(1);
        if (offer && within_limit && total_q != nkil_pkg::TOTAL_MAX) begin
          total_d = total_q + nkil_pkg::TOTAL_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q   <= '0;
      total_q <= '0;
    end else begin
      len_q   <= len_d;
      total_q <= total_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (exec_en) begin
      acc_q <= ins;
      pos_q <= ins ? pos_enc : '0;
      rv_q  <= (item_q.mode == nkil_pkg::MODE_READ) &&
               (int'(item_q.read_index) < int'(len_q));
    end
  end

  // ---------------- output register ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_q.accepted        <= acc_q;
      out_q.insert_position <= nkil_pkg::POS_W'(pos_q);
      out_q.kept_count      <= nkil_pkg::KEPT_W'(len_q);
      out_q.in_range_count  <= total_q;
      out_q.read_valid      <= rv_q;
      out_q.read_distance   <= rv_q ? rd_dist : '0;
      out_q.read_tag        <= rv_q ? rd_tag : '0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef NO_ASSERTIONS
  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q <= CntW'(LIST_CAPACITY))
    else $error("kept count exceeds list capacity");

  a_one_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (exec_en && ins) |-> $onehot(take_new_vec))
    else $error("insert did not select exactly one cell");

  a_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (exec_en && item_q.mode == nkil_pkg::MODE_CLEAR) |=> (len_q == '0 && total_q == '0))
    else $error("clear did not empty list and counter");

  a_load_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_out |-> $past(exec_en) || $past(state_q == nkil_pkg::ST_DONE))
    else $error("output loaded without a finished transaction");
`endif

endmodule
